>>> src/expression_line_tokenizer_core_defines.svh
// Assertion macros for the expression line tokenizer.
`ifndef EXPRESSION_LINE_TOKENIZER_CORE_DEFINES_SVH
`define EXPRESSION_LINE_TOKENIZER_CORE_DEFINES_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define ELT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define ELT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/elt_pkg.sv
package elt_pkg;

	localparam int LINE_SIZE = 4096;

	localparam int CHAR_W = 8;
	localparam int KIND_W = 4;
	localparam int POS_W  = 12;
	localparam int LEN_W  = 13;

	localparam logic [POS_W-1:0] POS_MAX = POS_W'(LINE_SIZE - 1);
	localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(LINE_SIZE);

	// Token kinds
	localparam logic [KIND_W-1:0] K_ADD    = 4'd0;
	localparam logic [KIND_W-1:0] K_SUB    = 4'd1;
	localparam logic [KIND_W-1:0] K_MUL    = 4'd2;
	localparam logic [KIND_W-1:0] K_DIV    = 4'd3;
	localparam logic [KIND_W-1:0] K_MOD    = 4'd4;
	localparam logic [KIND_W-1:0] K_EQU    = 4'd5;
	localparam logic [KIND_W-1:0] K_LPAREN = 4'd6;
	localparam logic [KIND_W-1:0] K_RPAREN = 4'd7;
	localparam logic [KIND_W-1:0] K_INT    = 4'd8;
	localparam logic [KIND_W-1:0] K_REAL   = 4'd9;
	localparam logic [KIND_W-1:0] K_IDENT  = 4'd10;
	localparam logic [KIND_W-1:0] K_NIL    = 4'd11;
	localparam logic [KIND_W-1:0] K_INVAL  = 4'd12;
	localparam logic [KIND_W-1:0] K_END    = 4'd13;

	// Pending token classes
	localparam logic [1:0] PC_NONE  = 2'd0;
	localparam logic [1:0] PC_IDENT = 2'd1;
	localparam logic [1:0] PC_NUM   = 2'd2;
	localparam logic [1:0] PC_SNUM  = 2'd3;

	// Characters
	localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;
	localparam logic [CHAR_W-1:0] CH_NL     = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
	localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
	localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2B;
	localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_STAR   = 8'h2A;
	localparam logic [CHAR_W-1:0] CH_SLASH  = 8'h2F;
	localparam logic [CHAR_W-1:0] CH_PCT    = 8'h25;
	localparam logic [CHAR_W-1:0] CH_EQ     = 8'h3D;
	localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
	localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
	localparam logic [CHAR_W-1:0] CH_DOT    = 8'h2E;
	localparam logic [CHAR_W-1:0] CH_UNDER  = 8'h5F;
	localparam logic [CHAR_W-1:0] CH_N      = 8'h6E;
	localparam logic [CHAR_W-1:0] CH_I      = 8'h69;
	localparam logic [CHAR_W-1:0] CH_L      = 8'h6C;

	// Results per character and bundle queue depth
	localparam int MAX_TOK = 3;
	localparam int QDEPTH  = 4;
	localparam int QAW     = $clog2(QDEPTH);

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [POS_W-1:0]  start;
		logic [LEN_W-1:0]  len;
	} tok_t;

	typedef struct packed {
		tok_t [MAX_TOK-1:0] toks;
		logic [1:0]         cnt;
	} bundle_t;

	typedef struct packed {
		logic    vld;
		bundle_t data;
	} qlink_t;

	function automatic logic is_digit(input logic [CHAR_W-1:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic is_alpha(input logic [CHAR_W-1:0] c);
		return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
	endfunction

	function automatic logic is_word(input logic [CHAR_W-1:0] c);
		return is_digit(c) || is_alpha(c) || (c == CH_UNDER);
	endfunction

	function automatic logic [CHAR_W-1:0] kw_char(input logic [1:0] idx);
		logic [CHAR_W-1:0] r;
		case (idx)
			2'd0:    r = CH_N;
			2'd1:    r = CH_I;
			default: r = CH_L;
		endcase
		return r;
	endfunction

	function automatic logic [POS_W-1:0] pos_inc(input logic [POS_W-1:0] p);
		return (p >= POS_MAX) ? POS_MAX : p + 1'b1;
	endfunction

	function automatic logic [LEN_W-1:0] len_inc(input logic [LEN_W-1:0] l);
		return (l >= LEN_MAX) ? LEN_MAX : l + 1'b1;
	endfunction

endpackage

>>> src/elt_front.sv
module elt_front
	import elt_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              take,
	input  logic [CHAR_W-1:0] character,
	output qlink_t            q_wr
);

	logic [POS_W-1:0] pos_q, pos_d;
	logic [1:0]       pc_q, pc_d;
	logic [POS_W-1:0] pstart_q, pstart_d;
	logic [LEN_W-1:0] plen_q, plen_d;
	logic             sd_q, sd_d;
	logic             sg_q, sg_d;
	logic             ao_q, ao_d;
	logic             am_q, am_d;
	logic [1:0]       kwp_q, kwp_d;

	tok_t [MAX_TOK:0] tk;
	logic [1:0]       n;
	logic             fresh, ended, op_hit;
	logic [KIND_W-1:0] op_k;

	always_comb begin
		tk       = '0;
		n        = '0;
		fresh    = 1'b1;
		ended    = 1'b0;
		op_hit   = 1'b0;
		op_k     = K_ADD;
		pos_d    = pos_q;
		pc_d     = pc_q;
		pstart_d = pstart_q;
		plen_d   = plen_q;
		sd_d     = sd_q;
		sg_d     = sg_q;
		ao_d     = ao_q;
		am_d     = am_q;
		kwp_d    = kwp_q;

		// Extend or flush the pending token
		if (pc_q == PC_IDENT) begin
			if (is_word(character)) begin
				if (plen_q < LEN_W'(3) && kwp_q == plen_q[1:0]
						&& character == kw_char(plen_q[1:0])) begin
					kwp_d = kwp_q + 2'd1;
				end
				plen_d = len_inc(plen_q);
				fresh  = 1'b0;
			end else begin
				tk[n] = '{(plen_q == LEN_W'(3) && kwp_q == 2'd3) ? K_NIL : K_IDENT,
					pstart_q, plen_q};
				n    = n + 2'd1;
				ao_d = 1'b0;
				am_d = 1'b1;
				pc_d = PC_NONE;
			end
		end else if (pc_q == PC_NUM || pc_q == PC_SNUM) begin
			if (is_digit(character) || (character == CH_DOT && !sd_q)) begin
				if (character == CH_DOT) begin
					sd_d = 1'b1;
				end else begin
					sg_d = 1'b1;
				end
				plen_d = len_inc(plen_q);
				fresh  = 1'b0;
			end else begin
				ao_d = 1'b0;
				if (sg_q) begin
					tk[n] = '{sd_q ? K_REAL : K_INT, pstart_q, plen_q};
					n     = n + 2'd1;
					am_d  = (pc_q == PC_NUM);
				end else if (pc_q == PC_NUM) begin
					tk[n] = '{K_INVAL, pstart_q, LEN_W'(1)};
					n     = n + 2'd1;
					am_d  = 1'b1;
				end else begin
					tk[n] = '{K_INVAL, pstart_q, LEN_W'(1)};
					n     = n + 2'd1;
					am_d  = 1'b0;
					// lone dot after a failed sign
					if (sd_q) begin
						tk[n] = '{K_INVAL, pos_inc(pstart_q), LEN_W'(1)};
						n     = n + 2'd1;
						am_d  = 1'b1;
					end
				end
				pc_d = PC_NONE;
			end
		end else begin
			pc_d = PC_NONE;
		end

		// Handle the character on its own
		if (fresh) begin
			unique case (character) inside
				CH_PLUS:   begin op_hit = 1'b1; op_k = K_ADD;    end
				CH_MINUS:  begin op_hit = 1'b1; op_k = K_SUB;    end
				CH_STAR:   begin op_hit = 1'b1; op_k = K_MUL;    end
				CH_SLASH:  begin op_hit = 1'b1; op_k = K_DIV;    end
				CH_PCT:    begin op_hit = 1'b1; op_k = K_MOD;    end
				CH_EQ:     begin op_hit = 1'b1; op_k = K_EQU;    end
				CH_LPAREN: begin op_hit = 1'b1; op_k = K_LPAREN; end
				CH_RPAREN: begin op_hit = 1'b1; op_k = K_RPAREN; end
				CH_SPACE, CH_TAB: begin
					am_d = 1'b0;
				end
				CH_NUL, CH_NL: begin
					tk[n]    = '{K_END, pos_q, LEN_W'(1)};
					n        = n + 2'd1;
					ended    = 1'b1;
					pos_d    = '0;
					pc_d     = PC_NONE;
					pstart_d = '0;
					plen_d   = '0;
					sd_d     = 1'b0;
					sg_d     = 1'b0;
					ao_d     = 1'b1;
					am_d     = 1'b0;
					kwp_d    = '0;
				end
				default: begin
					if ((is_word(character) || character == CH_DOT) && !am_d) begin
						pc_d     = (is_digit(character) || character == CH_DOT) ?
							PC_NUM : PC_IDENT;
						pstart_d = pos_q;
						plen_d   = LEN_W'(1);
						sd_d     = (character == CH_DOT);
						sg_d     = is_digit(character);
						kwp_d    = (character == CH_N) ? 2'd1 : 2'd0;
						am_d     = 1'b1;
					end else begin
						tk[n] = '{K_INVAL, pos_q, LEN_W'(1)};
						n     = n + 2'd1;
						am_d  = 1'b0;
						ao_d  = 1'b0;
					end
				end
			endcase
			if (op_hit) begin
				if (op_k <= K_SUB && ao_d) begin
					pc_d     = PC_SNUM;
					pstart_d = pos_q;
					plen_d   = LEN_W'(1);
					sd_d     = 1'b0;
					sg_d     = 1'b0;
					kwp_d    = '0;
					ao_d     = 1'b0;
					am_d     = 1'b0;
				end else begin
					tk[n] = '{op_k, pos_q, LEN_W'(1)};
					n     = n + 2'd1;
					ao_d  = (op_k <= K_EQU);
					am_d  = 1'b0;
				end
			end
		end

		if (!ended) begin
			pos_d = pos_inc(pos_q);
		end
	end

	assign q_wr.vld       = take && (n != 2'd0);
	assign q_wr.data.toks = tk[MAX_TOK-1:0];
	assign q_wr.data.cnt  = n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			pc_q     <= PC_NONE;
			pstart_q <= '0;
			plen_q   <= '0;
			sd_q     <= 1'b0;
			sg_q     <= 1'b0;
			ao_q     <= 1'b1;
			am_q     <= 1'b0;
			kwp_q    <= '0;
		end else if (take) begin
			pos_q    <= pos_d;
			pc_q     <= pc_d;
			pstart_q <= pstart_d;
			plen_q   <= plen_d;
			sd_q     <= sd_d;
			sg_q     <= sg_d;
			ao_q     <= ao_d;
			am_q     <= am_d;
			kwp_q    <= kwp_d;
		end
	end

endmodule

>>> src/elt_queue.sv
module elt_queue
	import elt_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  qlink_t q_wr,
	output logic   full,
	input  logic   rd_en,
	output qlink_t q_rd
);

	bundle_t        mem_q [QDEPTH];
	logic [QAW:0]   wp_q, rp_q;

	assign full = (wp_q[QAW] != rp_q[QAW]) && (wp_q[QAW-1:0] == rp_q[QAW-1:0]);

	assign q_rd.vld  = (wp_q != rp_q);
	assign q_rd.data = mem_q[rp_q[QAW-1:0]];

	always_ff @(posedge clk) begin
		if (q_wr.vld && !full) begin
			mem_q[wp_q[QAW-1:0]] <= q_wr.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
		end else begin
			if (q_wr.vld && !full) begin
				wp_q <= wp_q + 1'b1;
			end
			if (rd_en && q_rd.vld) begin
				rp_q <= rp_q + 1'b1;
			end
		end
	end

endmodule

>>> src/elt_back.sv
module elt_back
	import elt_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  qlink_t            q_rd,
	output logic              rd_en,
	output logic              empty,
	input  logic              pop,
	output logic [KIND_W-1:0] token_kind,
	output logic [POS_W-1:0]  token_start,
	output logic [LEN_W-1:0]  token_length,
	output logic              last_of_run
);

	bundle_t    bund_q;
	logic       valid_q;
	logic [1:0] idx_q;
	logic       last;
	tok_t       cur;

	assign last  = (idx_q == bund_q.cnt - 2'd1);
	assign rd_en = q_rd.vld && (!valid_q || (pop && last));
	assign empty = !valid_q;

	assign cur          = bund_q.toks[idx_q];
	assign token_kind   = cur.kind;
	assign token_start  = cur.start;
	assign token_length = cur.len;
	assign last_of_run  = last;

	always_ff @(posedge clk) begin
		if (rd_en) begin
			bund_q <= q_rd.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (rd_en) begin
			valid_q <= 1'b1;
			idx_q   <= '0;
		end else if (pop && valid_q) begin
			if (last) begin
				valid_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

endmodule

>>> src/expression_line_tokenizer_core.sv
// Expression line tokenizer: push one character of a calculator line per word
// on the input queue side and pop tokens (kind, start offset, length, and a
// last_of_run flag on the final token a character causes) from the output
// queue side. The front classifies a character in the cycle it is pushed, so
// full only rises when the four-entry bundle queue behind it is full. Each
// character yields zero to three tokens, and the back hands them out one per
// cycle through its output register while pop is held, so the output port sets
// the sustained rate; characters that yield no token take no room in the queue.
// A NUL or newline flushes whatever is pending, emits an end token and starts
// the next line at offset zero. No clearing pass follows reset.
`include "expression_line_tokenizer_core_defines.svh"

module expression_line_tokenizer_core
	import elt_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic [CHAR_W-1:0] character,
	output logic              empty,
	input  logic              pop,
	output logic [KIND_W-1:0] token_kind,
	output logic [POS_W-1:0]  token_start,
	output logic [LEN_W-1:0]  token_length,
	output logic              last_of_run
);

	qlink_t q_wr;
	qlink_t q_rd;
	logic   rd_en;
	logic   take;

	// Accept a character only when the bundle queue can take its tokens
	assign take = push && !full;

	// Front: classify, hold the pending token, emit a bundle of tokens
	elt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.character (character),
		.q_wr      (q_wr)
	);

	// Queue of token bundles between front and back
	elt_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.q_wr   (q_wr),
		.full   (full),
		.rd_en  (rd_en),
		.q_rd   (q_rd)
	);

	// Back: drain one bundle a token at a time
	elt_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_rd         (q_rd),
		.rd_en        (rd_en),
		.empty        (empty),
		.pop          (pop),
		.token_kind   (token_kind),
		.token_start  (token_start),
		.token_length (token_length),
		.last_of_run  (last_of_run)
	);

	// An end token always closes the run of its character
	`ELT_ASSERT_NOW(a_end_is_last, !empty && token_kind == K_END, last_of_run, "end token not last")

	// End of line always produces a bundle
	`ELT_ASSERT_NOW(a_eol_emits, take && (character == CH_NUL || character == CH_NL), q_wr.vld, "end of line lost")

	// No empty bundle ever reaches the back
	`ELT_ASSERT_NOW(a_bundle_nonzero, q_rd.vld, q_rd.data.cnt != 2'd0, "empty bundle queued")

	// A run does not stop before its last token
	`ELT_ASSERT_NEXT(a_run_continues, !empty && pop && !last_of_run, !empty, "run cut short")

endmodule

>>> test/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import elt_pkg::*;

	// Give up well past the slowest legal run: about 160 characters, at most three
	// tokens each, every token waiting out a long receiver stall.
	localparam int CYCLE_LIMIT = 100000;
	// Long enough for the bundle queue to fill and full to rise.
	localparam int HOLD_CYCLES = 80;
	// Keep clocking this long after the last token so that a stray extra shows up.
	localparam int DRAIN_CYCLES = 20;
	localparam int RANDOM_PER_PHASE = 24;

	localparam logic [CHAR_W-1:0] DIGIT_0 = 8'h30;
	localparam logic [CHAR_W-1:0] DIGIT_9 = 8'h39;
	localparam logic [CHAR_W-1:0] LOWER_A = 8'h61;
	localparam logic [CHAR_W-1:0] LOWER_Z = 8'h7A;
	localparam logic [CHAR_W-1:0] UPPER_A = 8'h41;
	localparam logic [CHAR_W-1:0] UPPER_Z = 8'h5A;

	// One token as it leaves the output side.
	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [POS_W-1:0]  start;
		logic [LEN_W-1:0]  len;
		logic              last;
	} token_t;

	// One row of the directed script. When typed is set the character causes exactly
	// one token, and the token written here replaces the predicted one.
	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic              typed;
		logic [KIND_W-1:0] kind;
		logic [POS_W-1:0]  start;
		logic [LEN_W-1:0]  len;
	} script_row_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              push = 1'b0;
	logic [CHAR_W-1:0] character = '0;
	logic              pop = 1'b0;
	logic              full;
	logic              empty;
	logic [KIND_W-1:0] token_kind;
	logic [POS_W-1:0]  token_start;
	logic [LEN_W-1:0]  token_length;
	logic              last_of_run;

	expression_line_tokenizer_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.character    (character),
		.empty        (empty),
		.pop          (pop),
		.token_kind   (token_kind),
		.token_start  (token_start),
		.token_length (token_length),
		.last_of_run  (last_of_run)
	);

	always #6 clk = ~clk;

	// Tokens still owed by the block, oldest first, and the tokens of the character
	// the predictor just handled.
	token_t tokens_due[$];
	token_t char_tokens[$];

	int mismatches = 0;
	int cycles = 0;
	int chars_sent = 0;
	int idle_pct = 0;
	int stall_pct = 0;
	int hold_requests = 0;

	// Tokenizer state kept by the predictor.
	logic [POS_W-1:0] line_pos;
	logic [1:0]       pend_cls;
	logic [POS_W-1:0] pend_start;
	logic [LEN_W-1:0] pend_len;
	logic             dot_seen;
	logic             digit_seen;
	logic             op_before;
	logic             multi_before;
	logic [1:0]       nil_prog;

	logic [CHAR_W-1:0] nil_word [3] = '{CH_N, CH_I, CH_L};
	logic [CHAR_W-1:0] op_chars [8] = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH,
		CH_PCT, CH_EQ, CH_LPAREN, CH_RPAREN};

	// Directed script. Line one walks every operator but the slash, a sign that turns out to be
	// an invalid and drags its dot along with it, a second dot closing a real, nil, an
	// identifier that runs into a dot, a lone dot, a signed integer and a high byte.
	script_row_t script [27] = '{
		'{CH_NL,     1'b1, K_END,    12'd0,  13'd1},
		'{CH_LPAREN, 1'b1, K_LPAREN, 12'd0,  13'd1},
		'{CH_MINUS,  1'b1, K_SUB,    12'd1,  13'd1},
		'{CH_PLUS,   1'b0, K_END,    12'd0,  13'd0},
		'{CH_DOT,    1'b0, K_END,    12'd0,  13'd0},
		'{CH_PCT,    1'b0, K_END,    12'd0,  13'd0},
		'{CH_DOT,    1'b0, K_END,    12'd0,  13'd0},
		'{"7",       1'b0, K_END,    12'd0,  13'd0},
		'{CH_DOT,    1'b0, K_END,    12'd0,  13'd0},
		'{CH_N,      1'b0, K_END,    12'd0,  13'd0},
		'{CH_I,      1'b0, K_END,    12'd0,  13'd0},
		'{CH_L,      1'b0, K_END,    12'd0,  13'd0},
		'{CH_SPACE,  1'b0, K_END,    12'd0,  13'd0},
		'{"x",       1'b0, K_END,    12'd0,  13'd0},
		'{"9",       1'b0, K_END,    12'd0,  13'd0},
		'{CH_UNDER,  1'b0, K_END,    12'd0,  13'd0},
		'{CH_DOT,    1'b0, K_END,    12'd0,  13'd0},
		'{CH_EQ,     1'b1, K_EQU,    12'd16, 13'd1},
		'{CH_TAB,    1'b0, K_END,    12'd0,  13'd0},
		'{CH_RPAREN, 1'b1, K_RPAREN, 12'd18, 13'd1},
		'{CH_PLUS,   1'b1, K_ADD,    12'd19, 13'd1},
		'{CH_DOT,    1'b0, K_END,    12'd0,  13'd0},
		'{CH_STAR,   1'b0, K_END,    12'd0,  13'd0},
		'{CH_PLUS,   1'b0, K_END,    12'd0,  13'd0},
		'{"3",       1'b0, K_END,    12'd0,  13'd0},
		'{8'h80,     1'b0, K_END,    12'd0,  13'd0},
		'{CH_NUL,    1'b1, K_END,    12'd25, 13'd1}
	};

	int idle_by_phase  [4] = '{0, 71, 0, 18};
	int stall_by_phase [4] = '{0, 0, 71, 18};

	function automatic bit numeral(input logic [CHAR_W-1:0] c);
		return c >= DIGIT_0 && c <= DIGIT_9;
	endfunction

	function automatic bit word_char(input logic [CHAR_W-1:0] c);
		return numeral(c) || (c >= LOWER_A && c <= LOWER_Z) ||
			(c >= UPPER_A && c <= UPPER_Z) || c == CH_UNDER;
	endfunction

	function automatic logic [POS_W-1:0] bump_pos(input logic [POS_W-1:0] p);
		return (p >= POS_MAX) ? POS_MAX : p + 1'b1;
	endfunction

	function automatic logic [LEN_W-1:0] bump_len(input logic [LEN_W-1:0] l);
		return (l >= LEN_MAX) ? LEN_MAX : l + 1'b1;
	endfunction

	function automatic void add_token(input logic [KIND_W-1:0] kind,
		input logic [POS_W-1:0] start, input logic [LEN_W-1:0] len);
		if (char_tokens.size() < MAX_TOK)
			char_tokens.push_back('{kind, start, len, 1'b0});
	endfunction

	// Start of a line: nothing pending, a sign may open a number.
	function automatic void rearm_line();
		line_pos = '0;
		pend_cls = PC_NONE;
		pend_start = '0;
		pend_len = '0;
		dot_seen = 1'b0;
		digit_seen = 1'b0;
		op_before = 1'b1;
		multi_before = 1'b0;
		nil_prog = '0;
	endfunction

	function automatic void begin_token(input logic [1:0] cls, input logic [POS_W-1:0] pos,
		input logic [CHAR_W-1:0] c);
		pend_cls = cls;
		pend_start = pos;
		pend_len = 13'd1;
		dot_seen = (c == CH_DOT);
		digit_seen = numeral(c);
		nil_prog = (c == nil_word[0]) ? 2'd1 : 2'd0;
	endfunction

	// Handle a character with nothing pending; return 1 when it ended the line.
	function automatic bit take_fresh(input logic [CHAR_W-1:0] c, input logic [POS_W-1:0] pos);
		logic [KIND_W-1:0] kind;
		case (c)
			CH_PLUS:   kind = K_ADD;
			CH_MINUS:  kind = K_SUB;
			CH_STAR:   kind = K_MUL;
			CH_SLASH:  kind = K_DIV;
			CH_PCT:    kind = K_MOD;
			CH_EQ:     kind = K_EQU;
			CH_LPAREN: kind = K_LPAREN;
			CH_RPAREN: kind = K_RPAREN;
			CH_SPACE, CH_TAB: begin
				multi_before = 1'b0;
				return 1'b0;
			end
			CH_NUL, CH_NL: begin
				add_token(K_END, pos, 13'd1);
				rearm_line();
				return 1'b1;
			end
			default: begin
				// A word character or dot glued onto a multi-character token is invalid.
				if ((word_char(c) || c == CH_DOT) && !multi_before) begin
					begin_token((numeral(c) || c == CH_DOT) ? PC_NUM : PC_IDENT, pos, c);
					multi_before = 1'b1;
				end else begin
					add_token(K_INVAL, pos, 13'd1);
					multi_before = 1'b0;
					op_before = 1'b0;
				end
				return 1'b0;
			end
		endcase
		// A sign at line start or after a non-paren operator opens a signed number.
		if (kind <= K_SUB && op_before) begin
			begin_token(PC_SNUM, pos, c);
			op_before = 1'b0;
			multi_before = 1'b0;
			return 1'b0;
		end
		add_token(kind, pos, 13'd1);
		op_before = (kind <= K_EQU);
		multi_before = 1'b0;
		return 1'b0;
	endfunction

	// Advance the predicted tokenizer by one character; fill char_tokens.
	function automatic void predict_tokens(input logic [CHAR_W-1:0] c);
		logic [POS_W-1:0] pos;
		bit               ended;
		char_tokens.delete();
		pos = line_pos;
		if (pend_cls == PC_IDENT) begin
			if (word_char(c)) begin
				if (pend_len < 13'd3 && nil_prog == pend_len[1:0] && c == nil_word[pend_len[1:0]])
					nil_prog = nil_prog + 1'b1;
				pend_len = bump_len(pend_len);
				line_pos = bump_pos(pos);
				return;
			end
			add_token((pend_len == 13'd3 && nil_prog == 2'd3) ? K_NIL : K_IDENT,
				pend_start, pend_len);
			op_before = 1'b0;
			multi_before = 1'b1;
		end else if (pend_cls != PC_NONE) begin
			if (numeral(c) || (c == CH_DOT && !dot_seen)) begin
				if (c == CH_DOT)
					dot_seen = 1'b1;
				else
					digit_seen = 1'b1;
				pend_len = bump_len(pend_len);
				line_pos = bump_pos(pos);
				return;
			end
			op_before = 1'b0;
			if (digit_seen) begin
				add_token(dot_seen ? K_REAL : K_INT, pend_start, pend_len);
				// A signed number does not block a token glued onto it.
				multi_before = (pend_cls == PC_NUM);
			end else if (pend_cls == PC_NUM) begin
				add_token(K_INVAL, pend_start, 13'd1);
				multi_before = 1'b1;
			end else begin
				// Failed sign: the sign is invalid, and a dot behind it is a lone dot.
				add_token(K_INVAL, pend_start, 13'd1);
				multi_before = 1'b0;
				if (dot_seen) begin
					add_token(K_INVAL, bump_pos(pend_start), 13'd1);
					multi_before = 1'b1;
				end
			end
		end
		pend_cls = PC_NONE;
		ended = take_fresh(c, pos);
		if (!ended)
			line_pos = bump_pos(pos);
		if (char_tokens.size() > 0)
			char_tokens[char_tokens.size() - 1].last = 1'b1;
	endfunction

	// Offer one word, hold it until accepted, then log what it should produce.
	task automatic send_char(input logic [CHAR_W-1:0] c, input bit typed = 1'b0,
		input token_t typed_tok = '0);
		while ($urandom_range(99) < idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		character <= c;
		do
			@(posedge clk);
		while (full);
		predict_tokens(c);
		if (typed)
			tokens_due.push_back(typed_tok);
		else
			foreach (char_tokens[i])
				tokens_due.push_back(char_tokens[i]);
		chars_sent++;
	endtask

	function automatic logic [CHAR_W-1:0] any_word_char(input bit lead);
		int r;
		r = lead ? $urandom_range(52) : $urandom_range(62);
		if (r < 26)
			return LOWER_A + 8'(r);
		if (r < 52)
			return UPPER_A + 8'(r - 26);
		if (r == 52)
			return CH_UNDER;
		return DIGIT_0 + 8'(r - 53);
	endfunction

	// Send one random piece of a line: mostly well-formed tokens, some noise.
	task automatic send_fragment();
		int pick;
		pick = $urandom_range(99);
		if (pick < 25) begin
			if ($urandom_range(2) == 0)
				send_char($urandom_range(1) ? CH_PLUS : CH_MINUS);
			repeat ($urandom_range(1, 4))
				send_char(DIGIT_0 + 8'($urandom_range(9)));
			if ($urandom_range(2) == 0) begin
				send_char(CH_DOT);
				repeat ($urandom_range(3))
					send_char(DIGIT_0 + 8'($urandom_range(9)));
			end
		end else if (pick < 45) begin
			if ($urandom_range(5) == 0) begin
				send_char(CH_N);
				send_char(CH_I);
				send_char(CH_L);
				repeat ($urandom_range(1))
					send_char(any_word_char(1'b0));
			end else begin
				send_char(any_word_char(1'b1));
				repeat ($urandom_range(5))
					send_char(any_word_char(1'b0));
			end
		end else if (pick < 65) begin
			send_char(op_chars[$urandom_range(7)]);
		end else if (pick < 78) begin
			send_char($urandom_range(1) ? CH_SPACE : CH_TAB);
		end else if (pick < 86) begin
			send_char($urandom_range(1) ? CH_NUL : CH_NL);
		end else begin
			send_char(8'($urandom_range(255)));
		end
	endtask

	// Receiver: check each popped token against the oldest one owed, then pick the
	// next pop. A hold request blocks pops until a countdown loaded from HOLD_CYCLES runs out.
	always @(posedge clk) begin : drain_tokens
		token_t want;
		int     hold_left;
		int     hold_served;
		if (!arst_n) begin
			pop <= 1'b0;
			hold_left = 0;
			hold_served = 0;
		end else begin
			if (pop && !empty) begin
				if (tokens_due.size() == 0) begin
					$error("unexpected token: kind %0d start %0d length %0d",
						token_kind, token_start, token_length);
					mismatches++;
				end else begin
					want = tokens_due.pop_front();
					if (token_kind !== want.kind) begin
						$error("token_kind: expected %0d, got %0d", want.kind, token_kind);
						mismatches++;
					end
					if (token_start !== want.start) begin
						$error("token_start: expected %0d, got %0d", want.start, token_start);
						mismatches++;
					end
					if (token_length !== want.len) begin
						$error("token_length: expected %0d, got %0d", want.len, token_length);
						mismatches++;
					end
					if (last_of_run !== want.last) begin
						$error("last_of_run: expected %0d, got %0d", want.last, last_of_run);
						mismatches++;
					end
				end
			end
			if (hold_served != hold_requests) begin
				hold_left = HOLD_CYCLES;
				hold_served++;
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else begin
				pop <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	// Watchdog: a hung handshake ends the run here.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		int target;
		rearm_line();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed script, no idling on either side.
		foreach (script[i])
			send_char(script[i].ch, script[i].typed,
				'{script[i].kind, script[i].start, script[i].len, 1'b1});

		// Random lines under each idling pattern.
		foreach (idle_by_phase[ph]) begin
			idle_pct = idle_by_phase[ph];
			stall_pct = stall_by_phase[ph];
			target = chars_sent + RANDOM_PER_PHASE;
			while (chars_sent < target)
				send_fragment();
		end

		// Back-pressure: hold the receiver off and keep pushing until full stalls us.
		idle_pct = 0;
		stall_pct = 0;
		hold_requests++;
		repeat (24)
			send_char(op_chars[$urandom_range(7)]);
		send_char(CH_NL);
		push <= 1'b0;

		while (tokens_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

>>> filelist.f
+incdir+src
src/elt_pkg.sv
src/elt_front.sv
src/elt_queue.sv
src/elt_back.sv
src/expression_line_tokenizer_core.sv
test/tb_top.sv
